>>> src/rsps_pkg.sv
`timescale 1ns / 1ps

package rsps_pkg;

  // Default sizes of the permutation store and of the sample budget.
  localparam int PERM_DEPTH_DEF    = 256;
  localparam int SAMPLE_BUDGET_DEF = 1024;

  // Field widths.
  localparam int WORD_W   = 32;
  localparam int SIZE_W   = 9;
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 8;
  localparam int ENTRY_W  = 8;
  localparam int STATUS_W = 3;

  // The table size register comes out of reset at 256.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // Command modes.
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUST  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RESTART  = 3'd5;

endpackage

>>> src/rsps_rem.sv
`timescale 1ns / 1ps

// Serial remainder unit: one restoring step per cycle over the 32 bits of
// the dividend. The remainder holds its value until the next start.
module rsps_rem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rsps_pkg::WORD_W-1:0]  dividend,
  input  logic [rsps_pkg::SIZE_W-1:0]  divisor,
  output logic                         done,
  output logic [rsps_pkg::SIZE_W-1:0]  remainder
);
  import rsps_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              running;
  logic [CNT_W-1:0]  step;
  logic [WORD_W-1:0] shreg;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic              fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {remainder, shreg[WORD_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  // Step sequencing and the partial remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running   <= 1'b1;
        step      <= '0;
        shreg     <= dividend;
        remainder <= '0;
      end else if (running) begin
        remainder <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        shreg     <= {shreg[WORD_W-2:0], 1'b0};
        step      <= step + CNT_W'(1);
        if (step == CNT_W'(WORD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/rejection_sampled_permutation_shuffle.sv
`timescale 1ns / 1ps
// An accepted sample takes the load, 32 steps and finish of the serial remainder unit,
// then the swap states S_RD_HI, S_RD_LO, S_WR_HI and S_WR_LO; a rejected one skips
// the swap. A read passes through S_RD_ENTRY, a restart fills one store entry per
// cycle, and all other commands answer from S_IDLE. A new command is taken in the
// cycle its result shows. Reset (synchronous, rst high) runs the same identity fill,
// busy high throughout it. Results are one-cycle strobes; the receiver cannot stall them.
module rejection_sampled_permutation_shuffle #(
  parameter int PERM_DEPTH    = rsps_pkg::PERM_DEPTH_DEF,
  parameter int SAMPLE_BUDGET = rsps_pkg::SAMPLE_BUDGET_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rsps_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic [rsps_pkg::MODE_W-1:0]    mode,
  input  logic [rsps_pkg::WORD_W-1:0]    random_sample,
  input  logic [rsps_pkg::INDEX_W-1:0]   entry_index,
  output logic                           done,
  output logic [rsps_pkg::STATUS_W-1:0]  status,
  output logic [rsps_pkg::ENTRY_W-1:0]   entry_value,
  output logic                           shuffle_done
);
  import rsps_pkg::*;

  localparam int AW          = $clog2(PERM_DEPTH);
  localparam int DEPTH_BITS  = $clog2(PERM_DEPTH + 1);
  localparam int CW          = (DEPTH_BITS > SIZE_W) ? DEPTH_BITS : SIZE_W;
  localparam int SUW         = $clog2(SAMPLE_BUDGET + 1);
  localparam int RESET_BOUND = (PERM_DEPTH < 256) ? PERM_DEPTH : 256;

  typedef enum logic [7:0] {
    S_FILL     = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_DIV      = 8'b0000_0100,
    S_RD_HI    = 8'b0000_1000,
    S_RD_LO    = 8'b0001_0000,
    S_WR_HI    = 8'b0010_0000,
    S_WR_LO    = 8'b0100_0000,
    S_RD_ENTRY = 8'b1000_0000
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   table_size;
  logic [SIZE_W-1:0]   bound;
  logic [SUW-1:0]      samples_used;
  logic [AW-1:0]       fill_addr;
  logic                fill_report;
  logic [WORD_W-1:0]   word;
  logic [ENTRY_W-1:0]  hold;

  logic [ENTRY_W-1:0]  perm_store [PERM_DEPTH];
  logic [ENTRY_W-1:0]  rd_data;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [AW-1:0]       mem_raddr;

  logic                div_start;
  logic                div_done;
  logic [SIZE_W-1:0]   div_rem;

  logic                accept;
  logic [CW-1:0]       active;
  logic                index_ok;
  logic [SIZE_W-1:0]   bound_dec;
  logic [AW-1:0]       hi_addr;
  logic [AW-1:0]       lo_addr;
  logic                swap_ok;
  logic [WORD_W-1:0]   base;
  logic [WORD_W:0]     top_sum;
  logic                reject;
  logic                bound_low;
  logic                budget_spent;

  // Command decode and the rejection test.
  always_comb begin
    accept       = start && (state == S_IDLE);
    busy         = (state != S_IDLE);
    active       = (CW'(table_size) > CW'(PERM_DEPTH)) ? CW'(PERM_DEPTH) : CW'(table_size);
    index_ok     = (CW'(entry_index) < active);
    bound_dec    = bound - SIZE_W'(1);
    bound_low    = (bound <= SIZE_W'(1));
    budget_spent = (samples_used >= SUW'(SAMPLE_BUDGET));
    hi_addr      = AW'(bound_dec);
    lo_addr      = AW'(div_rem);
    swap_ok      = (CW'(bound_dec) < CW'(PERM_DEPTH)) && (CW'(div_rem) < CW'(PERM_DEPTH));
    // The word lies above the last full multiple of the bound exactly when
    // its quotient is the top one and the remainder is not zero.
    base         = word - WORD_W'(div_rem);
    top_sum      = {1'b0, base} + (WORD_W + 1)'(bound);
    reject       = (div_rem != '0) && top_sum[WORD_W];
    div_start    = accept && (mode == MODE_SAMPLE) && !bound_low && !budget_spent;
  end

  // Store port selection for the fill sweep, the swap and the reads.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_addr;
    mem_wdata = ENTRY_W'(fill_addr);
    mem_raddr = hi_addr;
    unique case (state)
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_raddr = AW'(entry_index);
      end
      S_RD_LO: begin
        mem_raddr = lo_addr;
      end
      S_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_addr;
        mem_wdata = rd_data;
      end
      S_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_addr;
        mem_wdata = hold;
      end
      default: begin
        mem_raddr = hi_addr;
      end
    endcase
  end

  // Permutation store with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_store[mem_waddr] <= mem_wdata;
    end
    rd_data <= perm_store[mem_raddr];
  end

  rsps_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (random_sample),
    .divisor   (bound),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Command sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      fill_addr    <= '0;
      fill_report  <= 1'b0;
      bound        <= SIZE_W'(RESET_BOUND);
      samples_used <= '0;
      table_size   <= SIZE_RESET;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        table_size <= cfg_wdata;
      end
      unique case (state)
        S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == AW'(PERM_DEPTH - 1)) begin
            state     <= S_IDLE;
            fill_addr <= '0;
            if (fill_report) begin
              done         <= 1'b1;
              status       <= ST_RESTART;
              entry_value  <= '0;
              shuffle_done <= bound_low;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            word <= random_sample;
            case (mode)
              MODE_RESTART: begin
                state        <= S_FILL;
                fill_report  <= 1'b1;
                bound        <= SIZE_W'(active);
                samples_used <= '0;
              end
              MODE_SAMPLE: begin
                if (bound_low || budget_spent) begin
                  done         <= 1'b1;
                  status       <= bound_low ? ST_COMPLETE : ST_EXHAUST;
                  entry_value  <= '0;
                  shuffle_done <= bound_low;
                end else begin
                  samples_used <= samples_used + SUW'(1);
                  state        <= S_DIV;
                end
              end
              MODE_READ: begin
                if (index_ok) begin
                  state <= S_RD_ENTRY;
                end else begin
                  done         <= 1'b1;
                  status       <= ST_RANGE;
                  entry_value  <= '0;
                  shuffle_done <= bound_low;
                end
              end
              default: begin
                done         <= 1'b1;
                status       <= ST_RANGE;
                entry_value  <= '0;
                shuffle_done <= bound_low;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (reject) begin
              state        <= S_IDLE;
              done         <= 1'b1;
              status       <= ST_REJECTED;
              entry_value  <= '0;
              shuffle_done <= bound_low;
            end else if (swap_ok) begin
              state <= S_RD_HI;
            end else begin
              state        <= S_IDLE;
              bound        <= bound_dec;
              done         <= 1'b1;
              status       <= ST_OK;
              entry_value  <= '0;
              shuffle_done <= (bound_dec <= SIZE_W'(1));
            end
          end
        end
        S_RD_HI: begin
          state <= S_RD_LO;
        end
        S_RD_LO: begin
          // The read data now holds the upper entry of the swap.
          hold  <= rd_data;
          state <= S_WR_HI;
        end
        S_WR_HI: begin
          state <= S_WR_LO;
        end
        S_WR_LO: begin
          state        <= S_IDLE;
          bound        <= bound_dec;
          done         <= 1'b1;
          status       <= ST_OK;
          entry_value  <= '0;
          shuffle_done <= (bound_dec <= SIZE_W'(1));
        end
        S_RD_ENTRY: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          status       <= ST_OK;
          entry_value  <= rd_data;
          shuffle_done <= bound_low;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while the sequencer is busy");

  // Every accepted transaction either finishes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted transaction neither answered nor in progress");

  // The sample count only grows on an accepted sample transaction.
  a_samples_step: assert property (@(posedge clk) disable iff (rst)
    (!accept && !div_start) |=> (samples_used == $past(samples_used)))
    else $error("sample count changed without a sample transaction");

  // The bound never exceeds the store and the budget is never overrun.
  a_limits: assert property (@(posedge clk) disable iff (rst)
    (CW'(bound) <= CW'(PERM_DEPTH)) && (samples_used <= SUW'(SAMPLE_BUDGET)))
    else $error("bound or sample count out of range");

endmodule
